// ----- rtl/core/crpr_pkg.sv -----
// Shared types, constants and a decode function for the cab bus receive ping responder.
`default_nettype none
package crpr_pkg;

    localparam logic [7:0] CMD_BCAST       = 8'h80;
    localparam logic [7:0] CMD_SPEED_LO    = 8'h15;
    localparam logic [7:0] CMD_SPEED_HI    = 8'h16;
    localparam logic [7:0] CMD_TEXT_LO     = 8'hC0;
    localparam logic [7:0] CMD_TEXT_HI     = 8'hC7;
    localparam logic [7:0] CMD_CLOCK       = 8'hC8;
    localparam logic [7:0] CMD_LONG_TEXT   = 8'hCB;
    localparam logic [7:0] CMD_SINGLE      = 8'hCC;

    localparam logic [1:0] CAB_PING_FORM   = 2'b10;
    localparam logic [1:0] NB_ACK_FORM     = 2'b00;
    localparam logic [1:0] NB_INQUIRY_FORM = 2'b10;

    localparam logic CFG_CAB_ADDRESS  = 1'b0;
    localparam logic CFG_NINEBIT_MODE = 1'b1;

    localparam int CMD_ENTRY = 3;

    typedef struct packed {
        logic capture;
        logic decide;
        logic rd;
        logic emit;
        logic pad1;
        logic pad2;
        logic store;
        logic status;
    } crpr_cmd_t;

    typedef struct packed {
        logic op;
        logic sweep_go;
        logic pad_go;
        logic sweep_last;
        logic out_free;
    } crpr_stat_t;

    // Position n of a frame holds data of the command in entry 3
    function automatic logic is_command_data(input logic [7:0] cmd, input logic [7:0] n);
        logic r;
        r = 1'b0;
        if (cmd inside {[CMD_SPEED_LO:CMD_SPEED_HI]} && n inside {[8'd4:8'd5]}) r = 1'b1;
        if (cmd == CMD_LONG_TEXT && n inside {[8'd4:8'd12]}) r = 1'b1;
        if (cmd inside {[CMD_TEXT_LO:CMD_TEXT_HI]} && n inside {[8'd4:8'd11]}) r = 1'b1;
        if (cmd == CMD_CLOCK && n == 8'd4) r = 1'b1;
        if (cmd == CMD_SINGLE && n == 8'd4) r = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/crpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/core/crpr_datapath.sv -----
// Datapath: word capture, frame buffer, index, decode, status flags and output register.
`default_nettype none
module crpr_datapath #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire crpr_pkg::crpr_cmd_t   cmd,
    output crpr_pkg::crpr_stat_t       stat,
    input  wire logic [0:0]            s_tuser,
    input  wire logic [15:0]           s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tlast,
    output logic [0:0]                 m_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_index,
    input  wire logic [5:0]            cfg_wdata
);

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(BUFFER_DEPTH - 1);
    localparam logic [IW-1:0] IDX_PAD1 = IW'(1);
    localparam logic [IW-1:0] IDX_PAD2 = IW'(2);
    localparam logic [IW-1:0] IDX_CMD  = IW'(crpr_pkg::CMD_ENTRY);

    logic          op_reg, ninth_reg, err_reg, pend_reg;
    logic [7:0]    data_reg;
    logic [5:0]    cab_addr_reg;
    logic          nine_mode_reg;
    logic [IW-1:0] idx_reg, sweep_cnt_reg, rd_ptr_reg;
    logic          tx_reg;
    logic [7:0]    fb0_reg, fb3_reg;
    logic          ping_reg, rs_reg, ack_reg, col_reg;
    logic          out_valid_reg, out_kind_reg, out_last_reg;
    logic [7:0]    out_byte_reg;
    logic [3:0]    out_flags_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic cab_ping, nb_addr, nb_ack, nb_ping, restart, ping_hit, owner_hit, col_hit;
    logic out_free;

    always_comb begin
        cab_ping = !op_reg && !err_reg && !nine_mode_reg
                   && (data_reg[7:6] == crpr_pkg::CAB_PING_FORM)
                   && !crpr_pkg::is_command_data(fb3_reg, 8'(idx_reg));
        nb_addr  = !op_reg && !err_reg && nine_mode_reg && ninth_reg && !(^data_reg);
        nb_ack   = nb_addr && (data_reg[6:5] == crpr_pkg::NB_ACK_FORM)
                   && ({1'b0, data_reg[4:0]} == cab_addr_reg);
        nb_ping  = nb_addr && (data_reg[6:5] == crpr_pkg::NB_INQUIRY_FORM);
        restart  = cab_ping || nb_ping;
        ping_hit = (cab_ping && (data_reg[5:0] == cab_addr_reg))
                   || (nb_ping && ({1'b0, data_reg[4:0]} == cab_addr_reg));
        owner_hit = nine_mode_reg ? ({1'b0, fb0_reg[4:0]} == cab_addr_reg)
                                  : (fb0_reg[5:0] == cab_addr_reg);
        col_hit  = restart && owner_hit && (idx_reg > IDX_PAD1) && !tx_reg;
        out_free = !out_valid_reg || m_tready;

        stat.op         = op_reg;
        stat.sweep_go   = cab_ping && (fb0_reg == crpr_pkg::CMD_BCAST) && (idx_reg != '0);
        stat.pad_go     = !op_reg && !err_reg && !nine_mode_reg && !cab_ping
                          && (idx_reg == IDX_PAD1) && (fb0_reg == crpr_pkg::CMD_BCAST);
        stat.sweep_last = (rd_ptr_reg == sweep_cnt_reg - IW'(1));
        stat.out_free   = out_free;

        ram_we    = cmd.pad1 || cmd.pad2 || cmd.store;
        ram_waddr = cmd.pad1 ? IDX_PAD1 : (cmd.pad2 ? IDX_PAD2 : idx_reg);
        ram_wdata = cmd.store ? data_reg : 8'h00;
    end

    crpr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    // Captured word and flags carry no reset
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_tuser[0];
            data_reg  <= s_tdata[7:0];
            ninth_reg <= s_tdata[8];
            err_reg   <= s_tdata[9];
            pend_reg  <= s_tdata[10];
        end
        if (cmd.decide) begin
            ping_reg      <= ping_hit;
            rs_reg        <= ping_hit && pend_reg;
            ack_reg       <= nb_ack;
            col_reg       <= col_hit;
            sweep_cnt_reg <= idx_reg;
            rd_ptr_reg    <= '0;
        end
        if (cmd.emit) begin
            rd_ptr_reg <= rd_ptr_reg + IW'(1);
        end
        if (cmd.emit) begin
            out_kind_reg  <= 1'b1;
            out_byte_reg  <= ram_rdata;
            out_last_reg  <= 1'b0;
            out_flags_reg <= 4'b0000;
        end else if (cmd.status) begin
            out_kind_reg  <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_last_reg  <= 1'b1;
            out_flags_reg <= {col_reg, ack_reg, rs_reg, ping_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cab_addr_reg  <= '0;
            nine_mode_reg <= 1'b0;
            idx_reg       <= '0;
            tx_reg        <= 1'b0;
            fb0_reg       <= 8'h00;
            fb3_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    crpr_pkg::CFG_CAB_ADDRESS:  cab_addr_reg  <= cfg_wdata;
                    crpr_pkg::CFG_NINEBIT_MODE: nine_mode_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.decide) begin
                if (op_reg) begin
                    tx_reg <= 1'b1;
                end else if (restart) begin
                    tx_reg  <= 1'b0;
                    idx_reg <= '0;
                end
            end
            if (cmd.pad2) begin
                idx_reg <= IDX_CMD;
            end
            if (cmd.store) begin
                if (idx_reg == '0) begin
                    fb0_reg <= data_reg;
                end
                if (idx_reg == IDX_CMD) begin
                    fb3_reg <= data_reg;
                end
                if (idx_reg != IDX_LAST) begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            if (cmd.emit || cmd.status) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_flags_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

endmodule
`default_nettype wire

// ----- rtl/core/crpr_ctrl.sv -----
// Controller: sequences capture, decode, broadcast sweep, padding, store and status.
`default_nettype none
module crpr_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire crpr_pkg::crpr_stat_t stat,
    output crpr_pkg::crpr_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_EMIT,
        S_PAD1,
        S_PAD2,
        S_STORE,
        S_STATUS
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = aresetn;
                cmd.capture = s_tvalid && aresetn;
                if (s_tvalid && aresetn) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (stat.op) begin
                    state_next = S_STATUS;
                end else if (stat.sweep_go) begin
                    state_next = S_READ;
                end else if (stat.pad_go) begin
                    state_next = S_PAD1;
                end else begin
                    state_next = S_STORE;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.sweep_last ? S_STORE : S_READ;
                end
            end
            S_PAD1: begin
                cmd.pad1   = 1'b1;
                state_next = S_PAD2;
            end
            S_PAD2: begin
                cmd.pad2   = 1'b1;
                state_next = S_STORE;
            end
            S_STORE: begin
                cmd.store  = 1'b1;
                state_next = S_STATUS;
            end
            S_STATUS: begin
                if (stat.out_free) begin
                    cmd.status = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/cab_bus_rx_ping_responder_unit.sv -----
// Top level of the cab bus receive-side frame capture and ping responder.
//
// s_ channel: one word per received character (s_tuser = 1: our response
// transmission has started). m_ channel: for each input word, zero or more
// broadcast packet bytes (m_tuser = 1) and then one status word with
// m_tlast = 1. cfg channel writes cab_address (index 0) or ninebit_mode
// (index 1); it is ready outside reset and is to be used only while the
// block is idle, which the block does not enforce. One word is in flight at
// a time. A plain character passes through the decide, store and status
// states, and s_tready rises in the cycle its status word becomes valid; a
// pad insertion adds the PAD1 and PAD2 states. A ping that closes a
// broadcast frame of N bytes first reads them out of the frame buffer RAM
// one at a time (registered read, then output load). A single output
// register separates the channels; while the receiver holds m_tready low
// the sequencer waits at its next output load. Reset clears the index, the
// transmitting flag, the mirrored command bytes and the output valid flag;
// no clearing pass runs and s_tready rises right after.
`default_nettype none
module cab_bus_rx_ping_responder_unit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [7:0] rx_byte, [8] ninth_bit, [9] frame_error,
    //          [10] response_pending, [15:11] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    // s_tuser: [0] operation
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: [7:0] pkt_byte, [8] ping_for_us, [9] response_start,
    //          [10] ack_request, [11] collision, [15:12] zero
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    // m_tuser: [0] kind
    output logic [0:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_wdata
);

    crpr_pkg::crpr_cmd_t  cmd;
    crpr_pkg::crpr_stat_t stat;

    assign cfg_ready = aresetn;

    crpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crpr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire

// ----- tb/sv/crpr_frame_checker.sv -----
// Checker for the cab bus ping responder: frame capture predictor and result compare.
module crpr_frame_checker #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tlast,
    input  wire logic [0:0]  m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_wdata,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [7:0] pkt_byte;
        logic       last;
        logic       ping;
        logic       rsp_start;
        logic       ack;
        logic       coll;
    } rx_result_t;

    rx_result_t  expected_q[$];
    logic [7:0]  frame_mem [BUFFER_DEPTH];
    int unsigned wr_pos;
    logic        tx_active;
    logic [5:0]  my_addr;
    logic        nb_mode;
    int unsigned words_seen;

    task automatic note_mismatch(input string msg);
        $display("[%0t] crpr mismatch, result word %0d: %s", $realtime, words_seen, msg);
        fail_count++;
    endtask

    task automatic diff_field(input string fname, input logic [7:0] got,
                              input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0h want %0h", fname, got, want));
    endtask

    // True while position pos still belongs to the payload of command cmd
    function automatic logic in_cmd_payload(input logic [7:0] cmd, input int unsigned pos);
        logic [3:0] hi;
        hi = 4'd0;
        if (cmd == crpr_pkg::CMD_SPEED_LO || cmd == crpr_pkg::CMD_SPEED_HI) hi = 4'd5;
        else if (cmd == crpr_pkg::CMD_LONG_TEXT) hi = 4'd12;
        else if (cmd >= crpr_pkg::CMD_TEXT_LO && cmd <= crpr_pkg::CMD_TEXT_HI) hi = 4'd11;
        else if (cmd == crpr_pkg::CMD_CLOCK || cmd == crpr_pkg::CMD_SINGLE) hi = 4'd4;
        return hi != 4'd0 && pos >= 4 && pos <= hi;
    endfunction

    task automatic absorb_word(input logic op, input logic [7:0] b, input logic ninth,
                               input logic err, input logic pend);
        rx_result_t st;
        rx_result_t pb;
        int unsigned k;
        st = '0;
        st.last = 1'b1;
        if (op) begin
            tx_active = 1'b1;
        end else begin
            if (!err && nb_mode) begin
                if (ninth && (^b) == 1'b0) begin
                    if (b[6:5] == crpr_pkg::NB_ACK_FORM) begin
                        st.ack = ({1'b0, b[4:0]} == my_addr);
                    end else if (b[6:5] == crpr_pkg::NB_INQUIRY_FORM) begin
                        st.ping = ({1'b0, b[4:0]} == my_addr);
                        st.rsp_start = st.ping && pend;
                        st.coll = ({1'b0, frame_mem[0][4:0]} == my_addr) && wr_pos > 1
                                  && !tx_active;
                        tx_active = 1'b0;
                        wr_pos = 0;
                    end
                end
            end else if (!err) begin
                if (b[7:6] == crpr_pkg::CAB_PING_FORM
                    && !in_cmd_payload(frame_mem[3], wr_pos)) begin
                    st.ping = (b[5:0] == my_addr);
                    st.rsp_start = st.ping && pend;
                    if (frame_mem[0] == crpr_pkg::CMD_BCAST) begin
                        for (k = 0; k < wr_pos; k++) begin
                            pb = '0;
                            pb.kind = 1'b1;
                            pb.pkt_byte = frame_mem[k];
                            expected_q.push_back(pb);
                        end
                    end
                    st.coll = (frame_mem[0][5:0] == my_addr) && wr_pos > 1 && !tx_active;
                    tx_active = 1'b0;
                    wr_pos = 0;
                end
                // broadcast frames carry two zero pads after their first byte
                if (wr_pos == 1 && frame_mem[0] == crpr_pkg::CMD_BCAST) begin
                    frame_mem[1] = 8'h00;
                    frame_mem[2] = 8'h00;
                    wr_pos = 3;
                end
            end
            frame_mem[wr_pos] = b;
            if (wr_pos < BUFFER_DEPTH - 1) wr_pos++;
        end
        expected_q.push_back(st);
    endtask

    always @(posedge aclk) begin
        rx_result_t got;
        rx_result_t want;
        if (!aresetn) begin
            foreach (frame_mem[i]) frame_mem[i] = 8'h00;
            wr_pos = 0;
            tx_active = 1'b0;
            my_addr = 6'd0;
            nb_mode = 1'b0;
            expected_q.delete();
            fail_count = 0;
            words_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == crpr_pkg::CFG_CAB_ADDRESS) my_addr = cfg_wdata;
                else nb_mode = cfg_wdata[0];
            end
            if (s_tvalid && s_tready)
                absorb_word(s_tuser[0], s_tdata[7:0], s_tdata[8], s_tdata[9], s_tdata[10]);
            if (m_tvalid && m_tready) begin
                words_seen++;
                got.kind = m_tuser[0];
                got.pkt_byte = m_tdata[7:0];
                got.last = m_tlast;
                got.ping = m_tdata[8];
                got.rsp_start = m_tdata[9];
                got.ack = m_tdata[10];
                got.coll = m_tdata[11];
                if (expected_q.size() == 0) begin
                    note_mismatch("result word with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    diff_field("kind", 8'(got.kind), 8'(want.kind));
                    diff_field("pkt_byte", got.pkt_byte, want.pkt_byte);
                    diff_field("last", 8'(got.last), 8'(want.last));
                    diff_field("ping_for_us", 8'(got.ping), 8'(want.ping));
                    diff_field("response_start", 8'(got.rsp_start), 8'(want.rsp_start));
                    diff_field("ack_request", 8'(got.ack), 8'(want.ack));
                    diff_field("collision", 8'(got.coll), 8'(want.coll));
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// ----- tb/sv/cab_bus_rx_ping_responder_unit_tb.sv -----
// Testbench top for the cab bus ping responder: stimulus, flow control and verdict.
module cab_bus_rx_ping_responder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [15:0] s_tdata = 16'h0000;
    logic [0:0]  s_tuser = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [15:0] m_tdata;
    wire         m_tlast;
    wire  [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_wdata = 6'd0;

    int          fail_count;
    int          outstanding;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          chars_sent = 0;
    logic [5:0]  addr_now = 6'd0;
    logic        mode_now = 1'b0;

    always #1 aclk = ~aclk;

    cab_bus_rx_ping_responder_unit #(.BUFFER_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    crpr_frame_checker #(.BUFFER_DEPTH(DEPTH)) CHK (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    function automatic logic coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // receiver side; a hold-off keeps m_tready low long enough to back up the input
    initial begin : sink_side
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end else begin
                m_tready <= !coin(snk_stall_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic push_char(input logic op, input logic [7:0] b, input logic ninth,
                             input logic err, input logic pend);
        while (coin(src_idle_pct)) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, pend, err, ninth, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic set_reg(input logic idx, input logic [5:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle;
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic setup(input logic [5:0] a, input logic m, input int idle, input int stall);
        set_reg(crpr_pkg::CFG_CAB_ADDRESS, a);
        set_reg(crpr_pkg::CFG_NINEBIT_MODE, {5'd0, m});
        addr_now = a;
        mode_now = m;
        src_idle_pct = idle;
        snk_stall_pct = stall;
    endtask

    function automatic logic [7:0] pick_cmd;
        case ($urandom_range(7))
            0: return crpr_pkg::CMD_SPEED_LO;
            1: return crpr_pkg::CMD_SPEED_HI;
            2: return crpr_pkg::CMD_TEXT_LO + 8'($urandom_range(7));
            3: return crpr_pkg::CMD_CLOCK;
            4: return crpr_pkg::CMD_LONG_TEXT;
            5: return crpr_pkg::CMD_SINGLE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic cab_frame;
        int         len;
        int         j;
        int         pick;
        logic [5:0] a;
        logic [7:0] b;
        pick = $urandom_range(9);
        a = (pick < 4) ? addr_now : (pick < 7) ? 6'd0 : 6'($urandom);
        push_char(1'b0, {crpr_pkg::CAB_PING_FORM, a}, coin(50), coin(8), coin(50));
        len = coin(12) ? $urandom_range(10, 17) : $urandom_range(0, 5);
        for (j = 0; j < len; j++) begin
            // the command byte lands in entry 3 of the frame
            if (j == ((a == 6'd0) ? 0 : 2)) b = pick_cmd();
            else if (coin(25)) b = {crpr_pkg::CAB_PING_FORM, 6'($urandom)};
            else b = 8'($urandom);
            push_char(1'b0, b, coin(50), coin(6), coin(50));
        end
        if (coin(20)) push_char(1'b1, 8'($urandom), coin(50), coin(50), coin(50));
    endtask

    task automatic nb_frame;
        int         len;
        int         j;
        logic [1:0] form;
        logic [4:0] a5;
        logic [7:0] b;
        form = 2'($urandom);
        if (coin(70)) form = coin(50) ? crpr_pkg::NB_ACK_FORM : crpr_pkg::NB_INQUIRY_FORM;
        a5 = coin(50) ? addr_now[4:0] : 5'($urandom);
        b = {1'b0, form, a5};
        b[7] = ^b[6:0];
        if (coin(10)) b[7] = ~b[7];
        push_char(1'b0, b, !coin(10), coin(8), coin(50));
        len = coin(12) ? $urandom_range(10, 17) : $urandom_range(0, 6);
        for (j = 0; j < len; j++)
            push_char(1'b0, 8'($urandom), coin(10), coin(8), coin(50));
        if (coin(20)) push_char(1'b1, 8'($urandom), coin(50), coin(50), coin(50));
    endtask

    task automatic run_random(input int count);
        int stop;
        stop = chars_sent + count;
        while (chars_sent < stop) begin
            if (coin(10)) push_char(coin(10), 8'($urandom), coin(50), coin(50), coin(50));
            else if (mode_now) nb_frame();
            else cab_frame();
        end
    endtask

    initial begin : stimulus
        int         k;
        logic [7:0] b;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        setup(6'd0, 1'b0, 0, 0);
        push_char(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1);
        push_char(1'b0, crpr_pkg::CMD_BCAST, 1'b0, 1'b0, 1'b1);
        push_char(1'b0, crpr_pkg::CMD_TEXT_LO, 1'b0, 1'b0, 1'b0);
        // run the broadcast capture past the end of the buffer
        for (k = 0; k < 13; k++) begin
            b = (k == 0) ? 8'hBF : (k == 9) ? 8'hAA : (k[0] ? 8'hFF : 8'h00);
            push_char(1'b0, b, k[1], k == 9, k[2]);
        end
        push_char(1'b0, 8'h81, 1'b0, 1'b0, 1'b0);
        hold_off = 1'b1;
        run_random(60);
        settle();

        setup(6'd63, 1'b0, 85, 0);
        push_char(1'b0, 8'hBF, 1'b0, 1'b0, 1'b1);
        push_char(1'b0, 8'h11, 1'b0, 1'b0, 1'b0);
        push_char(1'b0, 8'hBF, 1'b0, 1'b0, 1'b0);
        run_random(70);
        settle();

        setup(6'($urandom), 1'b0, 0, 85);
        run_random(70);
        settle();

        setup(6'd31, 1'b1, 0, 0);
        push_char(1'b0, 8'h1F, 1'b1, 1'b0, 1'b0);
        push_char(1'b0, 8'h9F, 1'b1, 1'b0, 1'b0);
        push_char(1'b0, 8'h5F, 1'b1, 1'b0, 1'b1);
        push_char(1'b0, 8'h3F, 1'b1, 1'b0, 1'b0);
        push_char(1'b0, 8'hDF, 1'b0, 1'b0, 1'b0);
        run_random(60);
        settle();

        setup(6'd63, 1'b1, 30, 30);
        run_random(50);
        settle();

        setup(6'd0, 1'b1, 85, 0);
        run_random(40);
        settle();

        setup(6'($urandom), 1'b0, 30, 30);
        run_random(80);
        settle();

        if (fail_count == 0) begin
            $display("cab_bus_rx_ping_responder_unit_tb: done, clean");
        end else begin
            $display("cab_bus_rx_ping_responder_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("cab_bus_rx_ping_responder_unit_tb: done, errors");
        $finish;
    end

endmodule

// ----- cab_bus_rx_ping_responder_unit.f -----
rtl/core/crpr_pkg.sv
rtl/core/crpr_ram.sv
rtl/core/crpr_datapath.sv
rtl/core/crpr_ctrl.sv
rtl/core/cab_bus_rx_ping_responder_unit.sv
tb/sv/crpr_frame_checker.sv
tb/sv/cab_bus_rx_ping_responder_unit_tb.sv
